// ===== rtl/dcs_pkg.sv =====
// ----------------------------------------------------------------------------
// dcs_pkg
// Shared types and constants for the darkest circle selector: command codes,
// controller states and the command/status bundles between the two halves.
// ----------------------------------------------------------------------------
package dcs_pkg;

    // Default number of candidate circles per frame
    localparam int MAX_CIRCLES_DEF = 8;

    // Field widths fixed by the interface
    localparam int COORD_W = 8;
    localparam int PIX_W   = 8;
    localparam int SUM_W   = 24;
    localparam int IDX_OUT_W = 3;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int DIST_W  = SQ_W + 1;

    // A sum must fall strictly below this to qualify
    localparam logic [SUM_W-1:0] SUM_LIMIT = SUM_W'(9999999);
    // Saturation ceiling of each circle sum
    localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

    // Command codes on the cmd port
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_PIXEL = 2'd2
    } cmd_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_SCAN,
        ST_REPORT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear;       // zero the sums and the loaded count
        logic load;        // store one candidate circle
        logic pixel;       // register distances for an incoming pixel
        logic accum;       // add the pixel to every containing circle
        logic scan_start;  // restart the minimum search
        logic scan_step;   // compare one stored sum
    } dcs_ctl_t;

    // Status from datapath to controller
    typedef struct packed {
        logic last;         // the pixel in flight ends the image
        logic loaded_zero;  // no circle loaded in this frame
        logic scan_last;    // the search is at the last loaded circle
    } dcs_stat_t;

endpackage

// ===== rtl/dcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dcs_ctrl
// Controller: decodes accepted transactions, sequences the accumulate step,
// the minimum search and the one-cycle result strobe.
// ----------------------------------------------------------------------------
module dcs_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        cmd,
    input  dcs_pkg::dcs_stat_t stat,
    output dcs_pkg::dcs_ctl_t  ctl,
    output logic              busy,
    output logic              result_valid
);
    import dcs_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        ctl          = '0;
        result_valid = 1'b0;
        busy         = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    unique case (cmd_t'(cmd))
                        CMD_CLEAR: ctl.clear = 1'b1;
                        CMD_LOAD:  ctl.load  = 1'b1;
                        CMD_PIXEL:
                        begin
                            ctl.pixel  = 1'b1;
                            state_next = ST_ACCUM;
                        end
                        default: ; // unused code: drop the transaction
                    endcase
                end
            end
            ST_ACCUM:
            begin
                ctl.accum = 1'b1;
                if (stat.last)
                begin
                    ctl.scan_start = 1'b1;
                    state_next = stat.loaded_zero ? ST_REPORT : ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                result_valid = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/dcs_datapath.sv =====
// ----------------------------------------------------------------------------
// dcs_datapath
// Circle store, one containment lane per circle with registered squares,
// saturating per-circle sums and a sequential minimum search.
// ----------------------------------------------------------------------------
module dcs_datapath
#(
    parameter int MAX_CIRCLES = dcs_pkg::MAX_CIRCLES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  dcs_pkg::dcs_ctl_t             ctl,
    output dcs_pkg::dcs_stat_t            stat,
    input  logic [dcs_pkg::COORD_W-1:0]   circle_x,
    input  logic [dcs_pkg::COORD_W-1:0]   circle_y,
    input  logic [dcs_pkg::COORD_W-1:0]   circle_radius,
    input  logic [dcs_pkg::COORD_W-1:0]   pixel_x,
    input  logic [dcs_pkg::COORD_W-1:0]   pixel_y,
    input  logic [dcs_pkg::PIX_W-1:0]     pixel_value,
    input  logic                          last_pixel,
    output logic                          found,
    output logic [dcs_pkg::IDX_OUT_W-1:0] best_index,
    output logic [dcs_pkg::SUM_W-1:0]     best_sum
);
    import dcs_pkg::*;

    localparam int IDX_W = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
    localparam int CNT_W = $clog2(MAX_CIRCLES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CIRCLES);

    // Circle store and per-lane state
    logic [COORD_W-1:0] col_reg    [MAX_CIRCLES];
    logic [COORD_W-1:0] row_reg    [MAX_CIRCLES];
    logic [COORD_W-1:0] rad_reg    [MAX_CIRCLES];
    logic [SUM_W-1:0]   sum_reg    [MAX_CIRCLES];
    logic [SQ_W-1:0]    dx2_reg    [MAX_CIRCLES];
    logic [SQ_W-1:0]    dy2_reg    [MAX_CIRCLES];
    logic [SQ_W-1:0]    r2_reg     [MAX_CIRCLES];
    logic [MAX_CIRCLES-1:0] active_reg;

    logic [CNT_W-1:0]   loaded_reg;
    logic [PIX_W-1:0]   value_reg;
    logic               last_reg;

    // Minimum search
    logic [IDX_W-1:0]     idx_reg;
    logic [SUM_W-1:0]     best_reg;
    logic [IDX_OUT_W-1:0] best_idx_reg;
    logic                 found_reg;

    logic [IDX_W+IDX_OUT_W-1:0] idx_wide;
    logic [CNT_W:0]             idx_plus;
    logic [SUM_W-1:0]           scan_sum;

    // Loaded count and pixel bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                loaded_reg <= '0;
            end
            else if (ctl.load && (loaded_reg < MAX_CNT))
            begin
                loaded_reg <= loaded_reg + 1'b1;
            end
            if (ctl.pixel)
            begin
                last_reg <= last_pixel;
            end
        end
    end

    // Hold the pixel value for the accumulate step
    always_ff @(posedge clk)
    begin
        if (ctl.pixel)
        begin
            value_reg <= pixel_value;
        end
    end

    // Store a new circle in the next free slot; ignore loads when full
    always_ff @(posedge clk)
    begin
        if (ctl.load && (loaded_reg < MAX_CNT))
        begin
            col_reg[loaded_reg[IDX_W-1:0]] <= circle_x;
            row_reg[loaded_reg[IDX_W-1:0]] <= circle_y;
            rad_reg[loaded_reg[IDX_W-1:0]] <= circle_radius;
        end
    end

    // One containment lane per circle
    for (genvar k = 0; k < MAX_CIRCLES; k++)
    begin : g_lane
        logic [COORD_W-1:0] dx_abs;
        logic [COORD_W-1:0] dy_abs;
        logic [DIST_W-1:0]  dist2;
        logic               hit;
        logic [SUM_W:0]     sum_add;

        assign dx_abs = (pixel_x >= col_reg[k]) ? (pixel_x - col_reg[k])
                                                : (col_reg[k] - pixel_x);
        assign dy_abs = (pixel_y >= row_reg[k]) ? (pixel_y - row_reg[k])
                                                : (row_reg[k] - pixel_y);

        // Register the squares and the lane enable on pixel accept
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                active_reg[k] <= 1'b0;
            end
            else if (ctl.pixel)
            begin
                active_reg[k] <= (CNT_W'(k) < loaded_reg);
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.pixel)
            begin
                dx2_reg[k] <= SQ_W'(dx_abs) * SQ_W'(dx_abs);
                dy2_reg[k] <= SQ_W'(dy_abs) * SQ_W'(dy_abs);
                r2_reg[k]  <= SQ_W'(rad_reg[k]) * SQ_W'(rad_reg[k]);
            end
        end

        // Strict containment test and saturating add
        assign dist2   = DIST_W'(dx2_reg[k]) + DIST_W'(dy2_reg[k]);
        assign hit     = active_reg[k] && (dist2 < DIST_W'(r2_reg[k]));
        assign sum_add = (SUM_W+1)'(sum_reg[k]) + (SUM_W+1)'(value_reg);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sum_reg[k] <= '0;
            end
            else if (ctl.clear)
            begin
                sum_reg[k] <= '0;
            end
            else if (ctl.accum && hit)
            begin
                sum_reg[k] <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
            end
        end
    end

    // Sequential search for the first smallest qualifying sum
    assign scan_sum = sum_reg[idx_reg];
    assign idx_wide = {{IDX_OUT_W{1'b0}}, idx_reg};
    assign idx_plus = (CNT_W+1)'(idx_reg) + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            best_reg     <= SUM_LIMIT;
            best_idx_reg <= '0;
            found_reg    <= 1'b0;
        end
        else if (ctl.scan_start)
        begin
            idx_reg      <= '0;
            best_reg     <= SUM_LIMIT;
            best_idx_reg <= '0;
            found_reg    <= 1'b0;
        end
        else if (ctl.scan_step)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (scan_sum < best_reg)
            begin
                best_reg     <= scan_sum;
                best_idx_reg <= idx_wide[IDX_OUT_W-1:0];
                found_reg    <= 1'b1;
            end
        end
    end

    // Status back to the controller
    assign stat.last        = last_reg;
    assign stat.loaded_zero = (loaded_reg == '0);
    assign stat.scan_last   = (idx_plus == (CNT_W+1)'(loaded_reg));

    // Result fields read zero when no circle qualifies
    assign found      = found_reg;
    assign best_index = found_reg ? best_idx_reg : '0;
    assign best_sum   = found_reg ? best_reg : '0;

endmodule

// ===== rtl/darkest_circle_select.sv =====
// ----------------------------------------------------------------------------
// darkest_circle_select
// Accumulates pixel intensities inside up to MAX_CIRCLES candidate circles
// and reports the first circle with the smallest qualifying sum.
// ----------------------------------------------------------------------------
//  Channel   Handshake                  Payload
//  command   start in, busy out         cmd, circle_x/y, circle_radius,
//                                       pixel_x/y, pixel_value, last_pixel
//  result    result_valid out (strobe)  found, best_index, best_sum
//
//  Clear, load and unused commands keep busy low.
//  A pixel registers its squares in the accept cycle, then does the
//  per-circle compare and saturating add in all lanes at once.
//  A last pixel then runs the minimum search over the loaded circles in
//  the shared comparator, then holds result_valid high for one cycle.
//  Reset is asynchronous, active low, and empties the circle set and sums.
//  The result is shown for one cycle only; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module darkest_circle_select
#(
    parameter int MAX_CIRCLES = dcs_pkg::MAX_CIRCLES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    cmd,
    input  logic [dcs_pkg::COORD_W-1:0]   circle_x,
    input  logic [dcs_pkg::COORD_W-1:0]   circle_y,
    input  logic [dcs_pkg::COORD_W-1:0]   circle_radius,
    input  logic [dcs_pkg::COORD_W-1:0]   pixel_x,
    input  logic [dcs_pkg::COORD_W-1:0]   pixel_y,
    input  logic [dcs_pkg::PIX_W-1:0]     pixel_value,
    input  logic                          last_pixel,
    output logic                          result_valid,
    output logic                          found,
    output logic [dcs_pkg::IDX_OUT_W-1:0] best_index,
    output logic [dcs_pkg::SUM_W-1:0]     best_sum
);
    import dcs_pkg::*;

    dcs_ctl_t  ctl;
    dcs_stat_t stat;

    // Sequencer
    dcs_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .stat         (stat),
        .ctl          (ctl),
        .busy         (busy),
        .result_valid (result_valid)
    );

    // Circle lanes and minimum search
    dcs_datapath
    #(
        .MAX_CIRCLES (MAX_CIRCLES)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .circle_x      (circle_x),
        .circle_y      (circle_y),
        .circle_radius (circle_radius),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_value   (pixel_value),
        .last_pixel    (last_pixel),
        .found         (found),
        .best_index    (best_index),
        .best_sum      (best_sum)
    );

endmodule

// ===== rtl/dcs_checker.sv =====
// ----------------------------------------------------------------------------
// dcs_checker
// Port-level checks of the darkest circle selector, bound to the top level.
// ----------------------------------------------------------------------------
module dcs_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [1:0]                    cmd,
    input logic                          last_pixel,
    input logic                          result_valid,
    input logic                          found,
    input logic [dcs_pkg::IDX_OUT_W-1:0] best_index,
    input logic [dcs_pkg::SUM_W-1:0]     best_sum
);
    import dcs_pkg::*;

    // A result strobe lasts exactly one cycle
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    // A result is delivered while the block still reports busy
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result strobe while idle");

    // No qualifying circle: index and sum read zero
    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !found) |-> (best_index == '0 && best_sum == '0))
        else $error("nonzero result fields without a qualifying circle");

    // A reported sum lies below the qualifying limit
    a_found_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && found) |-> (best_sum < SUM_LIMIT))
        else $error("reported sum not below the limit");

    // An ordinary pixel transaction raises busy for the accumulate step, then returns to idle
    a_pixel_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == CMD_PIXEL && !last_pixel)
            |=> busy ##1 !busy)
        else $error("pixel transaction took the wrong number of cycles");

endmodule

bind darkest_circle_select dcs_checker u_dcs_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .last_pixel   (last_pixel),
    .result_valid (result_valid),
    .found        (found),
    .best_index   (best_index),
    .best_sum     (best_sum)
);

// ===== dv/darkest_circle_select_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// darkest_circle_select_checker
// Watches the command and result channels of the darkest circle selector.
// Keeps its own circle table and intensity sums, predicts the report for
// every accepted last pixel, and compares each result strobe field by field.
// ----------------------------------------------------------------------------
module darkest_circle_select_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [1:0]                    cmd,
    input  logic [dcs_pkg::COORD_W-1:0]   circle_x,
    input  logic [dcs_pkg::COORD_W-1:0]   circle_y,
    input  logic [dcs_pkg::COORD_W-1:0]   circle_radius,
    input  logic [dcs_pkg::COORD_W-1:0]   pixel_x,
    input  logic [dcs_pkg::COORD_W-1:0]   pixel_y,
    input  logic [dcs_pkg::PIX_W-1:0]     pixel_value,
    input  logic                          last_pixel,
    input  logic                          result_valid,
    input  logic                          found,
    input  logic [dcs_pkg::IDX_OUT_W-1:0] best_index,
    input  logic [dcs_pkg::SUM_W-1:0]     best_sum,
    output int                            mismatches,
    output int                            pending
);
    import dcs_pkg::*;

    localparam int NUM_SLOTS = MAX_CIRCLES_DEF;

    typedef struct packed {
        logic                 hit;
        logic [IDX_OUT_W-1:0] slot;
        logic [SUM_W-1:0]     total;
    } darkest_t;

    // Circle table and running sums of the current frame
    logic [COORD_W-1:0] slot_col [NUM_SLOTS];
    logic [COORD_W-1:0] slot_row [NUM_SLOTS];
    logic [COORD_W-1:0] slot_rad [NUM_SLOTS];
    logic [SUM_W-1:0]   slot_sum [NUM_SLOTS];
    int                 slots_used;

    darkest_t           expected_darkest [$];
    darkest_t           oldest;
    darkest_t           pick;
    logic [SUM_W-1:0]   floor_sum;
    logic [SUM_W:0]     wide;
    int                 dx;
    int                 dy;
    int                 rad;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_SLOTS; k++)
            begin
                slot_col[k] = '0;
                slot_row[k] = '0;
                slot_rad[k] = '0;
                slot_sum[k] = '0;
            end
            slots_used = 0;
            expected_darkest.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            // Compare the strobed result with the oldest prediction
            if (result_valid)
            begin
                if (expected_darkest.size() == 0)
                begin
                    mismatches++;
                    $display({"%0t: unexpected result, expected none, ",
                              "actual found=%0d index=%0d sum=%0d"},
                             $time, found, best_index, best_sum);
                end
                else
                begin
                    oldest = expected_darkest.pop_front();
                    if (found !== oldest.hit)
                    begin
                        mismatches++;
                        $display("%0t: found mismatch, expected %0d, actual %0d",
                                 $time, oldest.hit, found);
                    end
                    if (best_index !== oldest.slot)
                    begin
                        mismatches++;
                        $display("%0t: best_index mismatch, expected %0d, actual %0d",
                                 $time, oldest.slot, best_index);
                    end
                    if (best_sum !== oldest.total)
                    begin
                        mismatches++;
                        $display("%0t: best_sum mismatch, expected %0d, actual %0d",
                                 $time, oldest.total, best_sum);
                    end
                end
            end

            // Fold the accepted transaction into the frame state
            if (start && !busy)
            begin
                case (cmd)
                    CMD_CLEAR:
                    begin
                        for (int k = 0; k < NUM_SLOTS; k++)
                        begin
                            slot_sum[k] = '0;
                        end
                        slots_used = 0;
                    end
                    CMD_LOAD:
                    begin
                        // Drop loads once the table is full
                        if (slots_used < NUM_SLOTS)
                        begin
                            slot_col[slots_used] = circle_x;
                            slot_row[slots_used] = circle_y;
                            slot_rad[slots_used] = circle_radius;
                            slots_used++;
                        end
                    end
                    CMD_PIXEL:
                    begin
                        // Add the pixel to every circle that strictly holds it
                        for (int k = 0; k < slots_used; k++)
                        begin
                            dx  = int'(pixel_x) - int'(slot_col[k]);
                            dy  = int'(pixel_y) - int'(slot_row[k]);
                            rad = int'(slot_rad[k]);
                            if (dx * dx + dy * dy < rad * rad)
                            begin
                                wide = slot_sum[k] + pixel_value;
                                slot_sum[k] = (wide > SUM_MAX) ? SUM_MAX : wide[SUM_W-1:0];
                            end
                        end
                        // First smallest sum under the limit wins
                        if (last_pixel)
                        begin
                            pick = '0;
                            floor_sum = SUM_LIMIT;
                            for (int k = 0; k < slots_used; k++)
                            begin
                                if (slot_sum[k] < floor_sum)
                                begin
                                    floor_sum  = slot_sum[k];
                                    pick.hit   = 1'b1;
                                    pick.slot  = IDX_OUT_W'(k);
                                    pick.total = slot_sum[k];
                                end
                            end
                            expected_darkest.push_back(pick);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            pending = expected_darkest.size();
        end
    end

endmodule

// ===== dv/darkest_circle_select_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// darkest_circle_select_tb
// Drives frames of clear, load and pixel transactions into the darkest
// circle selector: a directed set of corner cases, then random frames with
// random idle gaps and stray commands. Checking lives in the checker.
// ----------------------------------------------------------------------------
module darkest_circle_select_tb;
    import dcs_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RESET_CYCLES       = 4;
    localparam int RANDOM_ITEMS       = 1500;
    localparam int STALL_LIMIT        = 2000;
    localparam int TAIL_CYCLES        = 32;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           cmd;
    logic [COORD_W-1:0]   circle_x;
    logic [COORD_W-1:0]   circle_y;
    logic [COORD_W-1:0]   circle_radius;
    logic [COORD_W-1:0]   pixel_x;
    logic [COORD_W-1:0]   pixel_y;
    logic [PIX_W-1:0]     pixel_value;
    logic                 last_pixel;
    logic                 result_valid;
    logic                 found;
    logic [IDX_OUT_W-1:0] best_index;
    logic [SUM_W-1:0]     best_sum;

    int                   mismatches;
    int                   pending;
    int                   idle_cycles = 0;
    int                   items_sent;
    int                   items_target;
    int                   frame_count;
    bit                   gaps_on;

    // Circles of the current frame, used to aim pixels at them
    int                   frame_loaded;
    logic [COORD_W-1:0]   frame_col [MAX_CIRCLES_DEF];
    logic [COORD_W-1:0]   frame_row [MAX_CIRCLES_DEF];
    logic [COORD_W-1:0]   frame_rad [MAX_CIRCLES_DEF];

    always #2 clk = ~clk;

    darkest_circle_select u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .circle_x      (circle_x),
        .circle_y      (circle_y),
        .circle_radius (circle_radius),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_value   (pixel_value),
        .last_pixel    (last_pixel),
        .result_valid  (result_valid),
        .found         (found),
        .best_index    (best_index),
        .best_sum      (best_sum)
    );

    darkest_circle_select_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .circle_x      (circle_x),
        .circle_y      (circle_y),
        .circle_radius (circle_radius),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_value   (pixel_value),
        .last_pixel    (last_pixel),
        .result_valid  (result_valid),
        .found         (found),
        .best_index    (best_index),
        .best_sum      (best_sum),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // Abort when no transaction moves on either channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic logic [7:0] any_byte();
        return 8'($urandom);
    endfunction

    // Coordinate within reach plus two of the centre on one axis, clamped to the image
    function automatic logic [7:0] near(input logic [7:0] centre, input logic [7:0] reach);
        int v;
        v = int'(centre) + int'($urandom_range(0, 2 * int'(reach) + 4)) - int'(reach) - 2;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 255)
        begin
            v = 255;
        end
        return 8'(v);
    endfunction

    // Present one transaction, hold it until accepted, then maybe idle
    task automatic issue(input logic [1:0] code, input logic [7:0] cx, input logic [7:0] cy,
                         input logic [7:0] cr, input logic [7:0] px, input logic [7:0] py,
                         input logic [7:0] pv, input logic lp);
        int gap;
        int roll;
        start         <= 1'b1;
        cmd           <= code;
        circle_x      <= cx;
        circle_y      <= cy;
        circle_radius <= cr;
        pixel_x       <= px;
        pixel_y       <= py;
        pixel_value   <= pv;
        last_pixel    <= lp;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        gap = 0;
        if (gaps_on)
        begin
            roll = $urandom_range(0, 99);
            if (roll >= 90)
            begin
                gap = $urandom_range(6, 30);
            end
            else if (roll >= 55)
            begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_clear();
        issue(CMD_CLEAR, any_byte(), any_byte(), any_byte(), any_byte(), any_byte(),
              any_byte(), 1'($urandom));
        frame_loaded = 0;
        items_sent++;
    endtask

    task automatic send_load(input logic [7:0] cx, input logic [7:0] cy, input logic [7:0] cr);
        issue(CMD_LOAD, cx, cy, cr, any_byte(), any_byte(), any_byte(), 1'($urandom));
        if (frame_loaded < MAX_CIRCLES_DEF)
        begin
            frame_col[frame_loaded] = cx;
            frame_row[frame_loaded] = cy;
            frame_rad[frame_loaded] = cr;
            frame_loaded++;
            items_sent++;
        end
    endtask

    task automatic send_pixel(input logic [7:0] px, input logic [7:0] py, input logic [7:0] pv,
                              input logic lp);
        issue(CMD_PIXEL, any_byte(), any_byte(), any_byte(), px, py, pv, lp);
        items_sent++;
    endtask

    // Hold off the sender until every predicted report has come back
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    // One frame: usually a clear, some loads, then pixels with stray commands mixed in
    task automatic random_frame();
        int n_load;
        int n_pix;
        int roll;
        int aim;
        logic [7:0] rad;
        logic [7:0] px;
        logic [7:0] py;
        logic [7:0] pv;
        logic lp;
        if ($urandom_range(0, 9) != 0)
        begin
            send_clear();
        end
        n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
        for (int i = 0; i < n_load; i++)
        begin
            rad = ($urandom_range(0, 4) == 0) ? any_byte() : 8'($urandom_range(0, 24));
            send_load(any_byte(), any_byte(), rad);
        end
        n_pix = $urandom_range(1, 24);
        for (int i = 0; i < n_pix; i++)
        begin
            roll = $urandom_range(0, 39);
            if (roll == 0)
            begin
                issue(CMD_UNUSED, any_byte(), any_byte(), any_byte(), any_byte(), any_byte(),
                      any_byte(), 1'($urandom));
            end
            else if (roll == 1)
            begin
                send_load(any_byte(), any_byte(), 8'($urandom_range(0, 24)));
            end
            else if (roll == 2)
            begin
                send_clear();
            end
            // Aim most pixels at a loaded circle so sums grow
            if (frame_loaded > 0 && $urandom_range(0, 9) < 7)
            begin
                aim = $urandom_range(0, frame_loaded - 1);
                px = near(frame_col[aim], frame_rad[aim]);
                py = near(frame_row[aim], frame_rad[aim]);
            end
            else
            begin
                px = any_byte();
                py = any_byte();
            end
            roll = $urandom_range(0, 9);
            pv = (roll == 0) ? 8'd0 : (roll == 1) ? 8'd255 : any_byte();
            if (i == n_pix - 1)
            begin
                lp = ($urandom_range(0, 9) != 0);
            end
            else
            begin
                lp = ($urandom_range(0, 14) == 0);
            end
            send_pixel(px, py, pv, lp);
        end
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        cmd           = CMD_CLEAR;
        circle_x      = '0;
        circle_y      = '0;
        circle_radius = '0;
        pixel_x       = '0;
        pixel_y       = '0;
        pixel_value   = '0;
        last_pixel    = 1'b0;
        gaps_on       = 1'b0;
        items_sent    = 0;
        frame_loaded  = 0;
        frame_count   = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Last pixel straight out of reset: no circles, nothing found
        send_pixel(8'd10, 8'd10, 8'd200, 1'b1);
        issue(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_clear();
        // Zero radius, full-size circle and unit circle
        send_load(8'd0, 8'd0, 8'd0);
        send_load(8'd255, 8'd255, 8'd255);
        send_load(8'd128, 8'd128, 8'd1);
        send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd0, 1'b0);
        send_pixel(8'd128, 8'd128, 8'd255, 1'b0);
        // Exactly on the rim, then just inside it
        send_pixel(8'd255, 8'd0, 8'd1, 1'b0);
        send_pixel(8'd255, 8'd1, 8'd7, 1'b0);
        send_pixel(8'd128, 8'd129, 8'd0, 1'b1);
        // Fill the table; the last load is dropped
        send_load(8'd10, 8'd20, 8'd5);
        send_load(8'd30, 8'd40, 8'd6);
        send_load(8'd50, 8'd60, 8'd7);
        send_load(8'd70, 8'd80, 8'd8);
        send_load(8'd90, 8'd100, 8'd9);
        send_load(8'd1, 8'd2, 8'd3);
        send_pixel(8'd128, 8'd128, 8'd255, 1'b1);
        drain();
        // Stored circles no longer count after a clear
        send_clear();
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        send_load(8'd200, 8'd200, 8'd3);
        send_pixel(8'd200, 8'd201, 8'd1, 1'b1);
        drain();

        // Random frames, some with idle gaps and some back to back
        items_target = items_sent + RANDOM_ITEMS;
        while (items_sent < items_target)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            random_frame();
            frame_count++;
            if (frame_count % 8 == 0)
            begin
                drain();
            end
        end

        gaps_on = 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
